@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the lexer RTL.
// Checks compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/slbs_pkg.sv @@
// ---------------------------------------------------------------------------
// Script lexer package
// Token codes, character constants and item types shared by the lexer files.
// ---------------------------------------------------------------------------
package slbs_pkg;

  // Token classes.
  typedef enum logic [3:0] {
    TC_NAME      = 4'd0,
    TC_NUMBER    = 4'd1,
    TC_ARITH     = 4'd2,
    TC_COMPARE   = 4'd3,
    TC_READIN    = 4'd4,
    TC_ASSIGN    = 4'd5,
    TC_LOGICAL   = 4'd6,
    TC_NEWLINE   = 4'd7,
    TC_SEMICOLON = 4'd8,
    TC_QUOTE     = 4'd9,
    TC_DEFINE    = 4'd10,
    TC_PUNCT     = 4'd11,
    TC_END       = 4'd12,
    TC_ERROR     = 4'd13
  } token_class_t;

  // Operator codes.
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_ADD    = 4'd1,
    OP_INC    = 4'd2,
    OP_SUB    = 4'd3,
    OP_DEC    = 4'd4,
    OP_LT     = 4'd5,
    OP_LE     = 4'd6,
    OP_GT     = 4'd7,
    OP_GE     = 4'd8,
    OP_EQ     = 4'd9,
    OP_NE     = 4'd10,
    OP_NOT    = 4'd11,
    OP_READIN = 4'd12
  } op_code_t;

  // What the lexer is holding between bytes.
  typedef enum logic [3:0] {
    PK_IDLE   = 4'd0,
    PK_NAME   = 4'd1,
    PK_NUMBER = 4'd2,
    PK_PLUS   = 4'd3,
    PK_MINUS  = 4'd4,
    PK_LT     = 4'd5,
    PK_GT     = 4'd6,
    PK_EQ     = 4'd7,
    PK_BANG   = 4'd8
  } pend_kind_t;

  // Source characters with a meaning of their own.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // Result queue depth and its index widths.
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_AW    = $clog2(RES_DEPTH);
  localparam int unsigned RES_CW    = $clog2(RES_DEPTH + 1);

  // One input item.
  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    token_class_t token_class;
    op_code_t     operator_code;
    logic [7:0]   symbol_byte;
    logic [7:0]   token_length;
    logic         too_long;
    logic [31:0]  start_position;
    logic [31:0]  line_number;
    logic         last;
  } result_t;

  // How many results the core pushes in one cycle.
  typedef struct packed {
    logic one;
    logic two;
  } push_t;

  // Result queue status seen by the top level.
  typedef struct packed {
    logic              room2;
    logic [RES_CW-1:0] count;
  } rq_stat_t;

endpackage

@@ hdl/slbs_stream_if.sv @@
// ---------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload item per handshake.
// ---------------------------------------------------------------------------
interface slbs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/slbs_result_fifo.sv @@
// ---------------------------------------------------------------------------
// Lexer result queue
// Small register queue taking up to two results a cycle and giving one.
// ---------------------------------------------------------------------------
module slbs_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  slbs_pkg::push_t  push,
  input  slbs_pkg::result_t d0,
  input  slbs_pkg::result_t d1,
  input  logic             pop,
  output logic             out_valid,
  output slbs_pkg::result_t out_data,
  output slbs_pkg::rq_stat_t stat
);
  import slbs_pkg::*;

  result_t           mem [RES_DEPTH];
  logic [RES_AW-1:0] wr_ptr;
  logic [RES_AW-1:0] rd_ptr;
  logic [RES_CW-1:0] count;
  logic [RES_CW-1:0] count_next;
  logic              do_pop;

  assign do_pop    = pop && (count != '0);
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign stat.room2 = (count <= RES_CW'(RES_DEPTH - 2));
  assign stat.count = count;

  // Occupancy after this cycle's pushes and pop.
  always_comb begin
    count_next = count;
    if (push.two) begin
      count_next = count_next + RES_CW'(2);
    end else if (push.one) begin
      count_next = count_next + RES_CW'(1);
    end
    if (do_pop) begin
      count_next = count_next - RES_CW'(1);
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_pop) begin
        rd_ptr <= rd_ptr + RES_AW'(1);
      end
      if (push.two) begin
        wr_ptr <= wr_ptr + RES_AW'(2);
      end else if (push.one) begin
        wr_ptr <= wr_ptr + RES_AW'(1);
      end
    end
  end

  // Entry storage; the second result goes right behind the first.
  always_ff @(posedge clk) begin
    if (push.one) begin
      mem[wr_ptr] <= d0;
    end
    if (push.two) begin
      mem[wr_ptr + RES_AW'(1)] <= d1;
    end
  end
endmodule

@@ hdl/slbs_core.sv @@
// ---------------------------------------------------------------------------
// Lexer core
// Holds the lexer state and turns one byte into zero, one or two tokens.
// ---------------------------------------------------------------------------
module slbs_core #(
  parameter int unsigned MAX_TOKEN_LEN = 255,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        c,
  output slbs_pkg::push_t   push,
  output slbs_pkg::result_t res0,
  output slbs_pkg::result_t res1
);
  import slbs_pkg::*;

  localparam int unsigned RunW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned PosW = (POSITION_BITS < 32) ? POSITION_BITS : 32;

  pend_kind_t      pending;
  pend_kind_t      pending_next;
  logic [RunW-1:0] run_len;
  logic [RunW-1:0] run_len_next;
  logic            tl_seen;
  logic            tl_seen_next;
  logic [PosW-1:0] pos;
  logic [PosW-1:0] tok_start;
  logic [PosW-1:0] tok_start_next;
  logic [31:0]     line_cnt;
  logic            line_inc;

  logic            is_letter;
  logic            is_digit;
  logic            pair_hit;
  token_class_t    pair_cls;
  op_code_t        pair_op;
  logic            extend;
  logic            f_valid;
  result_t         f_tok;
  logic            b_valid;
  result_t         b_tok;
  pend_kind_t      b_kind;
  logic            is_space;

  // Clamp a run count to the 8-bit length field.
  function automatic logic [7:0] sat_len(input logic [RunW-1:0] v);
    if (32'(v) > 32'd255) begin
      return 8'hFF;
    end
    return 8'(v);
  endfunction

  // Build one token; the line number is the count before this byte.
  function automatic result_t mk_tok(input token_class_t cls, input op_code_t op,
                                     input logic [7:0] sym, input logic [7:0] len,
                                     input logic tl, input logic [PosW-1:0] start,
                                     input logic [31:0] line);
    result_t r;
    r.token_class    = cls;
    r.operator_code  = op;
    r.symbol_byte    = sym;
    r.token_length   = len;
    r.too_long       = tl;
    r.start_position = 32'(start);
    r.line_number    = line;
    r.last           = 1'b0;
    return r;
  endfunction

  assign is_letter = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
                     ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  assign is_digit  = (c >= CH_0) && (c <= CH_9);
  assign is_space  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);

  // Second character of a two-character operator, or a run that grows.
  always_comb begin
    pair_hit = 1'b0;
    pair_cls = TC_ARITH;
    pair_op  = OP_NONE;
    extend   = 1'b0;
    unique case (pending)
      PK_NAME:   extend = is_letter || is_digit;
      PK_NUMBER: extend = is_digit;
      PK_PLUS: begin
        if (c == CH_PLUS) begin
          pair_hit = 1'b1;
          pair_op  = OP_INC;
        end
      end
      PK_MINUS: begin
        if (c == CH_MINUS) begin
          pair_hit = 1'b1;
          pair_op  = OP_DEC;
        end
      end
      PK_LT: begin
        if (c == CH_EQ) begin
          pair_hit = 1'b1;
          pair_cls = TC_COMPARE;
          pair_op  = OP_LE;
        end else if (c == CH_LT) begin
          pair_hit = 1'b1;
          pair_cls = TC_READIN;
          pair_op  = OP_READIN;
        end
      end
      PK_GT: begin
        if (c == CH_EQ) begin
          pair_hit = 1'b1;
          pair_cls = TC_COMPARE;
          pair_op  = OP_GE;
        end
      end
      PK_EQ: begin
        if (c == CH_EQ) begin
          pair_hit = 1'b1;
          pair_cls = TC_COMPARE;
          pair_op  = OP_EQ;
        end
      end
      PK_BANG: begin
        if (c == CH_EQ) begin
          pair_hit = 1'b1;
          pair_cls = TC_COMPARE;
          pair_op  = OP_NE;
        end
      end
      default: ;
    endcase
  end

  // Token for whatever is pending when this byte cannot extend it.
  always_comb begin
    f_valid = 1'b1;
    f_tok   = mk_tok(TC_ERROR, OP_NONE, CH_NUL, 8'd0, 1'b0, tok_start, line_cnt);
    unique case (pending)
      PK_NAME:   f_tok = mk_tok(TC_NAME, OP_NONE, CH_NUL, sat_len(run_len), tl_seen,
                                tok_start, line_cnt);
      PK_NUMBER: f_tok = mk_tok(TC_NUMBER, OP_NONE, CH_NUL, sat_len(run_len), tl_seen,
                                tok_start, line_cnt);
      PK_PLUS:   f_tok = mk_tok(TC_ARITH, OP_ADD, CH_PLUS, 8'd1, 1'b0, tok_start, line_cnt);
      PK_MINUS:  f_tok = mk_tok(TC_ARITH, OP_SUB, CH_MINUS, 8'd1, 1'b0, tok_start, line_cnt);
      PK_LT:     f_tok = mk_tok(TC_COMPARE, OP_LT, CH_LT, 8'd1, 1'b0, tok_start, line_cnt);
      PK_GT:     f_tok = mk_tok(TC_COMPARE, OP_GT, CH_GT, 8'd1, 1'b0, tok_start, line_cnt);
      PK_EQ:     f_tok = mk_tok(TC_ASSIGN, OP_NONE, CH_EQ, 8'd1, 1'b0, tok_start, line_cnt);
      PK_BANG:   f_tok = mk_tok(TC_LOGICAL, OP_NOT, CH_BANG, 8'd1, 1'b0, tok_start, line_cnt);
      default:   f_valid = 1'b0;
    endcase
  end

  // How this byte starts the next token.
  always_comb begin
    b_kind   = PK_IDLE;
    b_valid  = 1'b0;
    line_inc = 1'b0;
    b_tok    = mk_tok(TC_ERROR, OP_NONE, c, 8'd1, 1'b0, pos, line_cnt);
    if (is_letter) begin
      b_kind = PK_NAME;
    end else if (is_digit) begin
      b_kind = PK_NUMBER;
    end else if (!is_space) begin
      case (c) inside
        CH_PLUS:  b_kind = PK_PLUS;
        CH_MINUS: b_kind = PK_MINUS;
        CH_LT:    b_kind = PK_LT;
        CH_GT:    b_kind = PK_GT;
        CH_EQ:    b_kind = PK_EQ;
        CH_BANG:  b_kind = PK_BANG;
        default: begin
          b_valid = 1'b1;
          case (c) inside
            CH_NUL: b_tok = mk_tok(TC_END, OP_NONE, CH_NUL, 8'd0, 1'b0, pos, line_cnt);
            CH_LF: begin
              b_tok    = mk_tok(TC_NEWLINE, OP_NONE, CH_NUL, 8'd1, 1'b0, pos, line_cnt);
              line_inc = 1'b1;
            end
            CH_SEMI:  b_tok = mk_tok(TC_SEMICOLON, OP_NONE, c, 8'd1, 1'b0, pos, line_cnt);
            CH_SLASH, CH_STAR, CH_CARET, CH_PCT, CH_LPAREN, CH_RPAREN:
              b_tok = mk_tok(TC_ARITH, OP_NONE, c, 8'd1, 1'b0, pos, line_cnt);
            CH_DQUOTE, CH_SQUOTE:
              b_tok = mk_tok(TC_QUOTE, OP_NONE, c, 8'd1, 1'b0, pos, line_cnt);
            CH_HASH:  b_tok = mk_tok(TC_COMPARE, OP_NONE, c, 8'd1, 1'b0, pos, line_cnt);
            CH_COLON: b_tok = mk_tok(TC_DEFINE, OP_NONE, c, 8'd1, 1'b0, pos, line_cnt);
            CH_COMMA, CH_UNDER, CH_DOT:
              b_tok = mk_tok(TC_PUNCT, OP_NONE, c, 8'd1, 1'b0, pos, line_cnt);
            default: ;
          endcase
        end
      endcase
    end
  end

  // Pick the results of this byte and the next lexer state.
  always_comb begin
    pending_next   = pending;
    run_len_next   = run_len;
    tl_seen_next   = tl_seen;
    tok_start_next = tok_start;
    push           = '0;
    res0           = f_tok;
    res1           = b_tok;
    res1.last      = 1'b1;
    if (pair_hit) begin
      res0         = mk_tok(pair_cls, pair_op, CH_NUL, 8'd2, 1'b0, tok_start, line_cnt);
      res0.last    = 1'b1;
      push.one     = 1'b1;
      pending_next = PK_IDLE;
    end else if (extend) begin
      if (32'(run_len) >= MAX_TOKEN_LEN) begin
        tl_seen_next = 1'b1;
      end else begin
        run_len_next = run_len + RunW'(1);
      end
    end else begin
      pending_next = b_kind;
      run_len_next = '0;
      tl_seen_next = 1'b0;
      if (b_kind != PK_IDLE) begin
        tok_start_next = pos;
      end
      if ((b_kind == PK_NAME) || (b_kind == PK_NUMBER)) begin
        run_len_next = RunW'(1);
      end
      if (f_valid) begin
        push.one  = 1'b1;
        push.two  = b_valid;
        res0.last = !b_valid;
      end else if (b_valid) begin
        push.one  = 1'b1;
        res0      = b_tok;
        res0.last = 1'b1;
      end
    end
    if (!step) begin
      push = '0;
    end
  end

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= PK_IDLE;
      run_len   <= '0;
      tl_seen   <= 1'b0;
      pos       <= '0;
      tok_start <= '0;
      line_cnt  <= '0;
    end else if (step) begin
      pending   <= pending_next;
      run_len   <= run_len_next;
      tl_seen   <= tl_seen_next;
      pos       <= pos + PosW'(1);
      tok_start <= tok_start_next;
      if (line_inc && !pair_hit && !extend) begin
        line_cnt <= line_cnt + 32'd1;
      end
    end
  end
endmodule

@@ hdl/script_lexer_byte_stream.sv @@
// ---------------------------------------------------------------------------
// Script lexer, byte stream
// Classifies a stream of source bytes into name, number, operator and
// punctuation tokens with position and line information.
// ---------------------------------------------------------------------------
// The block takes one source byte per cycle, while the result queue has
// room, into an input register, and lexes a staged byte into zero, one or
// two tokens once the four-entry result queue has room for two. Tokens are
// registered in the queue and offered at the output from its head. The
// output port gives one token per cycle while the receiver is ready, so a
// byte that both ends a pending name, number or operator prefix and forms
// a one-character token of its own uses the output twice; the queue absorbs
// this and input stays at one byte per cycle as long as the output averages
// at most one token per cycle. MAX_TOKEN_LEN sets where name and
// number lengths saturate, and POSITION_BITS sets the wrap of the byte
// position counter (start positions report its low 32 bits).
module script_lexer_byte_stream #(
  parameter int unsigned MAX_TOKEN_LEN = 255,
  parameter int unsigned POSITION_BITS = 32
) (
  input logic          clk,
  input logic          rst,
  slbs_stream_if.sink   bytes,
  slbs_stream_if.source tokens
);
  import slbs_pkg::*;
  `include "assert_macros.svh"

  logic       in_valid;
  logic [7:0] in_byte;
  logic       fire;
  push_t      push;
  result_t    res0;
  result_t    res1;
  rq_stat_t   rq_stat;
  result_t    out_data;

  // Lex the staged byte once the queue has room for two tokens.
  assign fire        = in_valid && rq_stat.room2;
  assign bytes.ready = !in_valid || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_byte <= bytes.data.in_byte;
    end
  end

  slbs_core #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (fire),
    .c    (in_byte),
    .push (push),
    .res0 (res0),
    .res1 (res1)
  );

  slbs_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .d0        (res0),
    .d1        (res1),
    .pop       (tokens.ready),
    .out_valid (tokens.valid),
    .out_data  (out_data),
    .stat      (rq_stat)
  );

  assign tokens.data = out_data;

  // A staged byte that is not lexed stays staged.
  `ASSERT_NEXT(a_stage_hold, clk, rst, in_valid && !fire, in_valid)
  // The second token of a byte always comes with the first.
  `ASSERT_IMPLIES(a_push_order, clk, rst, push.two, push.one)
  // The queue never holds more than its depth.
  `ASSERT_IMPLIES(a_queue_bound, clk, rst, 1'b1, rq_stat.count <= RES_CW'(RES_DEPTH))
  // Pushes happen only when the queue had room for both tokens.
  `ASSERT_NEXT(a_no_overflow, clk, rst, push.one,
               rq_stat.count <= RES_CW'(RES_DEPTH))

endmodule

@@ tb/sv/script_lexer_byte_stream_test.sv @@
// ---------------------------------------------------------------------------
// Script lexer byte stream testbench
// Sends source bytes into the lexer and checks every token against a
// cycle-free predictor of the lexing rules. A short directed table comes
// first, then random text built mostly from well-formed tokens with noise.
// Both channels idle and stall at random, except during a steady run of bytes.
// ---------------------------------------------------------------------------
module script_lexer_byte_stream_test;
  import slbs_pkg::*;

  localparam int unsigned MAX_LEN      = 255;
  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned STEADY_FROM  = 700;
  localparam int unsigned STEADY_TO    = 1000;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam result_t NO_WANT = '0;
  localparam int unsigned DIR_ROWS = 29;

  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{CH_NUL,    1'b1, '{TC_END, OP_NONE, 8'h00, 8'd0, 1'b0, 32'd0, 32'd0, 1'b1}},
    '{8'hFF,     1'b1, '{TC_ERROR, OP_NONE, 8'hFF, 8'd1, 1'b0, 32'd1, 32'd0, 1'b1}},
    '{CH_LF,     1'b1, '{TC_NEWLINE, OP_NONE, 8'h00, 8'd1, 1'b0, 32'd2, 32'd0, 1'b1}},
    '{CH_SEMI,   1'b1, '{TC_SEMICOLON, OP_NONE, CH_SEMI, 8'd1, 1'b0, 32'd3, 32'd1, 1'b1}},
    '{CH_LOWER_A, 1'b0, NO_WANT},
    '{CH_9,      1'b0, NO_WANT},
    '{CH_PLUS,   1'b0, NO_WANT},
    '{CH_PLUS,   1'b0, NO_WANT},
    '{CH_PLUS,   1'b0, NO_WANT},
    '{CH_MINUS,  1'b0, NO_WANT},
    '{CH_MINUS,  1'b0, NO_WANT},
    '{CH_LT,     1'b0, NO_WANT},
    '{CH_EQ,     1'b0, NO_WANT},
    '{CH_LT,     1'b0, NO_WANT},
    '{CH_LT,     1'b0, NO_WANT},
    '{CH_GT,     1'b0, NO_WANT},
    '{CH_EQ,     1'b0, NO_WANT},
    '{CH_EQ,     1'b0, NO_WANT},
    '{CH_EQ,     1'b0, NO_WANT},
    '{CH_BANG,   1'b0, NO_WANT},
    '{CH_EQ,     1'b0, NO_WANT},
    '{CH_BANG,   1'b0, NO_WANT},
    '{CH_HASH,   1'b0, NO_WANT},
    '{8'h35,     1'b0, NO_WANT},
    '{CH_UPPER_Z, 1'b0, NO_WANT},
    '{CH_COLON,  1'b0, NO_WANT},
    '{CH_EQ,     1'b0, NO_WANT},
    '{CH_SPACE,  1'b0, NO_WANT},
    '{CH_NUL,    1'b0, NO_WANT}
  };

  localparam logic [7:0] PREFIX_CHARS [6] = '{CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_EQ, CH_BANG};
  localparam logic [7:0] LONE_CHARS [16] = '{
    CH_SEMI, CH_SLASH, CH_STAR, CH_CARET, CH_PCT, CH_LPAREN, CH_RPAREN, CH_DQUOTE,
    CH_SQUOTE, CH_HASH, CH_COLON, CH_COMMA, CH_UNDER, CH_DOT, CH_LF, CH_NUL
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  slbs_stream_if #(.T(in_item_t)) byte_ch ();
  slbs_stream_if #(.T(result_t))  token_ch ();

  script_lexer_byte_stream uut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .tokens (token_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lexer state as the predictor sees it.
  pend_kind_t  pend = PK_IDLE;
  int unsigned run_len = 0;
  logic        long_seen = 1'b0;
  logic [31:0] byte_pos = '0;
  logic [31:0] tok_start = '0;
  logic [31:0] line_cnt = '0;

  result_t     fresh_tokens[$];
  result_t     token_expect[$];
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  logic        steady_run = 1'b0;
  logic        failed = 1'b0;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  // Append one token; the length field clamps at 255.
  function automatic void add_token(token_class_t cls, op_code_t op, logic [7:0] sym,
                                    int unsigned len, logic tl, logic [31:0] start);
    result_t r;
    r.token_class    = cls;
    r.operator_code  = op;
    r.symbol_byte    = sym;
    r.token_length   = (len > 255) ? 8'd255 : 8'(len);
    r.too_long       = tl;
    r.start_position = start;
    r.line_number    = line_cnt;
    r.last           = 1'b0;
    fresh_tokens.push_back(r);
  endfunction

  // Emit whatever is pending as a finished token and go idle.
  function automatic void flush_pending();
    case (pend)
      PK_NAME:   add_token(TC_NAME, OP_NONE, 8'h00, run_len, long_seen, tok_start);
      PK_NUMBER: add_token(TC_NUMBER, OP_NONE, 8'h00, run_len, long_seen, tok_start);
      PK_PLUS:   add_token(TC_ARITH, OP_ADD, CH_PLUS, 1, 1'b0, tok_start);
      PK_MINUS:  add_token(TC_ARITH, OP_SUB, CH_MINUS, 1, 1'b0, tok_start);
      PK_LT:     add_token(TC_COMPARE, OP_LT, CH_LT, 1, 1'b0, tok_start);
      PK_GT:     add_token(TC_COMPARE, OP_GT, CH_GT, 1, 1'b0, tok_start);
      PK_EQ:     add_token(TC_ASSIGN, OP_NONE, CH_EQ, 1, 1'b0, tok_start);
      PK_BANG:   add_token(TC_LOGICAL, OP_NOT, CH_BANG, 1, 1'b0, tok_start);
      default: ;
    endcase
    pend      = PK_IDLE;
    run_len   = 0;
    long_seen = 1'b0;
  endfunction

  // Start a new token from byte c, or emit it at once if it stands alone; blanks do neither.
  function automatic void start_token(logic [7:0] c, logic [31:0] p);
    pend_kind_t k;
    k = PK_IDLE;
    if (c == CH_SPACE || c == CH_TAB || c == CH_CR) return;
    if (is_alpha(c) || is_num(c)) begin
      pend      = is_alpha(c) ? PK_NAME : PK_NUMBER;
      run_len   = 1;
      long_seen = 1'b0;
      tok_start = p;
      return;
    end
    case (c)
      CH_PLUS:  k = PK_PLUS;
      CH_MINUS: k = PK_MINUS;
      CH_LT:    k = PK_LT;
      CH_GT:    k = PK_GT;
      CH_EQ:    k = PK_EQ;
      CH_BANG:  k = PK_BANG;
      default: ;
    endcase
    if (k != PK_IDLE) begin
      pend      = k;
      tok_start = p;
      return;
    end
    case (c)
      CH_NUL: add_token(TC_END, OP_NONE, 8'h00, 0, 1'b0, p);
      CH_LF: begin
        add_token(TC_NEWLINE, OP_NONE, 8'h00, 1, 1'b0, p);
        line_cnt = line_cnt + 1;
      end
      CH_SEMI: add_token(TC_SEMICOLON, OP_NONE, c, 1, 1'b0, p);
      CH_SLASH, CH_STAR, CH_CARET, CH_PCT, CH_LPAREN, CH_RPAREN:
        add_token(TC_ARITH, OP_NONE, c, 1, 1'b0, p);
      CH_DQUOTE, CH_SQUOTE: add_token(TC_QUOTE, OP_NONE, c, 1, 1'b0, p);
      CH_HASH: add_token(TC_COMPARE, OP_NONE, c, 1, 1'b0, p);
      CH_COLON: add_token(TC_DEFINE, OP_NONE, c, 1, 1'b0, p);
      CH_COMMA, CH_UNDER, CH_DOT: add_token(TC_PUNCT, OP_NONE, c, 1, 1'b0, p);
      default: add_token(TC_ERROR, OP_NONE, c, 1, 1'b0, p);
    endcase
  endfunction

  // Work out the tokens that one accepted byte produces.
  function automatic void lex_byte(logic [7:0] c);
    logic [31:0]  p;
    token_class_t cls;
    op_code_t     op;
    logic         done;
    fresh_tokens.delete();
    p        = byte_pos;
    byte_pos = p + 1;
    done     = 1'b0;
    cls      = TC_NAME;
    op       = OP_NONE;
    case (pend)
      PK_NAME: begin
        if (is_alpha(c) || is_num(c)) begin
          if (run_len >= MAX_LEN) long_seen = 1'b1;
          else run_len++;
          done = 1'b1;
        end
      end
      PK_NUMBER: begin
        if (is_num(c)) begin
          if (run_len >= MAX_LEN) long_seen = 1'b1;
          else run_len++;
          done = 1'b1;
        end
      end
      PK_PLUS: if (c == CH_PLUS) begin cls = TC_ARITH; op = OP_INC; end
      PK_MINUS: if (c == CH_MINUS) begin cls = TC_ARITH; op = OP_DEC; end
      PK_LT: begin
        if (c == CH_EQ) begin cls = TC_COMPARE; op = OP_LE; end
        else if (c == CH_LT) begin cls = TC_READIN; op = OP_READIN; end
      end
      PK_GT: if (c == CH_EQ) begin cls = TC_COMPARE; op = OP_GE; end
      PK_EQ: if (c == CH_EQ) begin cls = TC_COMPARE; op = OP_EQ; end
      PK_BANG: if (c == CH_EQ) begin cls = TC_COMPARE; op = OP_NE; end
      default: ;
    endcase
    // A completed two-character operator consumes the byte.
    if (op != OP_NONE) begin
      add_token(cls, op, 8'h00, 2, 1'b0, tok_start);
      pend = PK_IDLE;
      done = 1'b1;
    end
    if (!done) begin
      flush_pending();
      start_token(c, p);
    end
    if (fresh_tokens.size() > 0) fresh_tokens[fresh_tokens.size() - 1].last = 1'b1;
  endfunction

  // Compare one received token with its expectation, field by field.
  function automatic void check_token(result_t want, result_t got);
    if (got.token_class !== want.token_class) begin
      $error("token_class: expected %0d, got %0d", want.token_class, got.token_class);
      failed = 1'b1;
    end
    if (got.operator_code !== want.operator_code) begin
      $error("operator_code: expected %0d, got %0d", want.operator_code, got.operator_code);
      failed = 1'b1;
    end
    if (got.symbol_byte !== want.symbol_byte) begin
      $error("symbol_byte: expected %0h, got %0h", want.symbol_byte, got.symbol_byte);
      failed = 1'b1;
    end
    if (got.token_length !== want.token_length) begin
      $error("token_length: expected %0d, got %0d", want.token_length, got.token_length);
      failed = 1'b1;
    end
    if (got.too_long !== want.too_long) begin
      $error("too_long: expected %0b, got %0b", want.too_long, got.too_long);
      failed = 1'b1;
    end
    if (got.start_position !== want.start_position) begin
      $error("start_position: expected %0d, got %0d", want.start_position, got.start_position);
      failed = 1'b1;
    end
    if (got.line_number !== want.line_number) begin
      $error("line_number: expected %0d, got %0d", want.line_number, got.line_number);
      failed = 1'b1;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last);
      failed = 1'b1;
    end
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'(CH_UPPER_A + $urandom_range(25))
                             : 8'(CH_LOWER_A + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CH_0 + $urandom_range(9));
  endfunction

  // Offer one byte, wait for the handshake, then record its tokens.
  task automatic send_byte(input logic [7:0] ch, input logic typed = 1'b0,
                           input result_t want = NO_WANT);
    if (!steady_run && $urandom_range(99) < 12) begin
      byte_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 25);
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.data.in_byte <= ch;
    do @(posedge clk); while (!byte_ch.ready);
    lex_byte(ch);
    if (typed) token_expect.push_back(want);
    else foreach (fresh_tokens[k]) token_expect.push_back(fresh_tokens[k]);
    sent_count++;
    steady_run = (sent_count >= STEADY_FROM) && (sent_count < STEADY_TO);
  endtask

  // Send one random token, mostly well formed, sometimes followed by a blank.
  task automatic send_random_token();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  first;
    logic [7:0]  blank;
    pick = $urandom_range(99);
    len  = ($urandom_range(99) < 2) ? ($urandom_range(1) ? $urandom_range(253, 258)
                                                          : $urandom_range(240, 300))
                                    : $urandom_range(1, 10);
    if (pick < 22) begin
      // Name: a letter, then letters and digits.
      send_byte(rand_letter());
      for (int unsigned k = 1; k < len; k++)
        send_byte($urandom_range(3) == 0 ? rand_digit() : rand_letter());
    end else if (pick < 36) begin
      // Number.
      for (int unsigned k = 0; k < len; k++) send_byte(rand_digit());
    end else if (pick < 52) begin
      // Operator prefix followed by a likely second character.
      first = PREFIX_CHARS[$urandom_range(5)];
      send_byte(first);
      case ($urandom_range(2))
        0: send_byte(CH_EQ);
        1: send_byte(first);
        default: send_byte(CH_LT);
      endcase
    end else if (pick < 64) begin
      send_byte(PREFIX_CHARS[$urandom_range(5)]);
    end else if (pick < 82) begin
      send_byte(LONE_CHARS[$urandom_range(15)]);
    end else if (pick < 88) begin
      send_byte(CH_NUL);
    end else begin
      // Noise over the whole byte range.
      send_byte(8'($urandom_range(255)));
    end
    if ($urandom_range(1)) begin
      case ($urandom_range(2))
        0: blank = CH_SPACE;
        1: blank = CH_TAB;
        default: blank = CH_CR;
      endcase
      send_byte(blank);
    end
  endtask

  // Token receiver: random stalls, checking on each handshake.
  always @(posedge clk) begin
    result_t want;
    if (rst) token_ch.ready <= 1'b0;
    else token_ch.ready <= steady_run || ($urandom_range(99) >= 12);
    if (!rst && token_ch.valid && token_ch.ready) begin
      if (token_expect.size() == 0) begin
        $error("token received with none expected: class %0d at %0d",
               token_ch.data.token_class, token_ch.data.start_position);
        failed = 1'b1;
      end else begin
        want = token_expect.pop_front();
        check_token(want, token_ch.data);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("script_lexer_byte_stream test failed");
      $finish;
    end
  end

  // Stimulus: reset, directed table, random text, then drain.
  initial begin
    byte_ch.valid        <= 1'b0;
    byte_ch.data.in_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int unsigned i = 0; i < DIR_ROWS; i++)
      send_byte(DIR_TABLE[i].ch, DIR_TABLE[i].typed, DIR_TABLE[i].want);
    while (sent_count < DIR_ROWS + RANDOM_ITEMS) send_random_token();
    byte_ch.valid <= 1'b0;
    while (token_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && token_expect.size() == 0) begin
      $display("script_lexer_byte_stream test passed");
    end else begin
      $display("script_lexer_byte_stream test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/slbs_pkg.sv
hdl/slbs_stream_if.sv
hdl/slbs_result_fifo.sv
hdl/slbs_core.sv
hdl/script_lexer_byte_stream.sv
tb/sv/script_lexer_byte_stream_test.sv
